// ===== src/char_lcd_nibble_write_controller_defines.svh =====
// assertion macros used by the char lcd nibble write controller rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef CHAR_LCD_NIBBLE_WRITE_CONTROLLER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define CLNW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLNW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/clnw_pkg.sv =====
// types, codes and microprogram rom of the char lcd nibble write controller
// no dependencies
package clnw_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] line_number;
    logic [7:0] line_length;
    logic [7:0] char_code;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic [5:0] wait_before_ms;
    logic [1:0] wait_after_ms;
    logic       last_res;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_LINE  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_FUNCTION_SET    = 2'd0,
    CFG_DISPLAY_CONTROL = 2'd1,
    CFG_ENTRY_MODE      = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned PcW      = 4;

  localparam logic [7:0] FunctionSetRst    = 8'h28;
  localparam logic [7:0] DisplayControlRst = 8'h0C;
  localparam logic [7:0] EntryModeRst      = 8'h06;
  localparam logic [7:0] CursorCmd         = 8'h80;
  localparam logic [7:0] ClearCmd          = 8'h01;
  localparam logic [7:0] SpaceChar         = 8'h20;
  localparam logic [7:0] WakeNib           = 8'h03;
  localparam logic [7:0] FourBitNib        = 8'h02;

  // microprogram entry points
  localparam logic [PcW-1:0] PcInit   = 4'd0;
  localparam logic [PcW-1:0] PcClear  = 4'd8;
  localparam logic [PcW-1:0] PcCursor = 4'd9;
  localparam logic [PcW-1:0] PcChar   = 4'd10;
  localparam logic [PcW-1:0] PcPad    = 4'd11;

  typedef enum logic [2:0] {
    SRC_LIT    = 3'd0,
    SRC_FSET   = 3'd1,
    SRC_DCTL   = 3'd2,
    SRC_ENTRY  = 3'd3,
    SRC_CURSOR = 3'd4,
    SRC_CHAR   = 3'd5
  } src_e;

  typedef enum logic [1:0] {
    NX_SEQ  = 2'd0,
    NX_DONE = 2'd1,
    NX_LINE = 2'd2,
    NX_PAD  = 2'd3
  } nxt_e;

  typedef struct packed {
    src_e       src;
    logic [7:0] lit;
    logic       single;
    logic       rs;
    logic       count;
    logic [5:0] wb;
    logic [1:0] wa;
    nxt_e       nxt;
  } ucode_t;

  typedef struct packed {
    logic [7:0] function_set;
    logic [7:0] display_control;
    logic [7:0] entry_mode;
  } cfg_t;

  typedef struct packed {
    logic           go;
    logic           clear_col;
    logic [PcW-1:0] entry;
    logic [7:0]     char_code;
    logic [7:0]     cursor;
    logic           last;
    logic           char_ok;
  } start_t;

  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      4'd0:  w = '{SRC_LIT, WakeNib, 1'b1, 1'b0, 1'b0, 6'd50, 2'd0, NX_SEQ};
      4'd1:  w = '{SRC_LIT, WakeNib, 1'b1, 1'b0, 1'b0, 6'd5, 2'd0, NX_SEQ};
      4'd2:  w = '{SRC_LIT, WakeNib, 1'b1, 1'b0, 1'b0, 6'd1, 2'd0, NX_SEQ};
      4'd3:  w = '{SRC_LIT, FourBitNib, 1'b1, 1'b0, 1'b0, 6'd0, 2'd0, NX_SEQ};
      4'd4:  w = '{SRC_FSET, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 2'd0, NX_SEQ};
      4'd5:  w = '{SRC_DCTL, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 2'd0, NX_SEQ};
      4'd6:  w = '{SRC_LIT, ClearCmd, 1'b0, 1'b0, 1'b0, 6'd0, 2'd2, NX_SEQ};
      4'd7:  w = '{SRC_ENTRY, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 2'd0, NX_DONE};
      4'd8:  w = '{SRC_LIT, ClearCmd, 1'b0, 1'b0, 1'b0, 6'd0, 2'd2, NX_DONE};
      4'd9:  w = '{SRC_CURSOR, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 2'd0, NX_LINE};
      4'd10: w = '{SRC_CHAR, 8'h00, 1'b0, 1'b1, 1'b1, 6'd0, 2'd0, NX_PAD};
      4'd11: w = '{SRC_LIT, SpaceChar, 1'b0, 1'b1, 1'b1, 6'd0, 2'd0, NX_PAD};
      default: w = '{SRC_LIT, 8'h00, 1'b1, 1'b0, 1'b0, 6'd0, 2'd0, NX_DONE};
    endcase
    return w;
  endfunction

endpackage

// ===== src/clnw_seq.sv =====
// microcoded nibble sequencer with column counter and output register
// depends on clnw_pkg and char_lcd_nibble_write_controller_defines.svh
`include "char_lcd_nibble_write_controller_defines.svh"

module clnw_seq #(
  parameter int unsigned LINE_WIDTH = 16,
  parameter int unsigned ColW       = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clnw_pkg::start_t     start_i,
  input  clnw_pkg::cfg_t       cfg_i,
  output logic                 busy_o,
  output logic [ColW-1:0]      col_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output clnw_pkg::out_item_t  out_data_o
);

  localparam logic [ColW-1:0] LineW = ColW'(LINE_WIDTH);

  logic                        run_q, run_d;
  logic                        half_q, half_d;
  logic [clnw_pkg::PcW-1:0]    pc_q, pc_d;
  logic [ColW-1:0]             col_q, col_d;
  logic [7:0]                  char_q, cursor_q;
  logic                        last_q, char_ok_q;
  logic                        out_valid_q, out_valid_d;
  clnw_pkg::out_item_t         out_q, out_d;

  clnw_pkg::ucode_t            uw;
  logic [7:0]                  byte_val;
  logic                        fire, byte_end, fin, pad_need;
  logic [ColW-1:0]             col_after;

  assign uw   = clnw_pkg::ucode_rom(pc_q);
  assign fire = run_q && (!out_valid_q || !out_stall_i);
  assign byte_end  = uw.single || half_q;
  assign col_after = uw.count ? col_q + ColW'(1) : col_q;
  assign pad_need  = last_q && (col_after < LineW);

  always_comb begin
    unique case (uw.src)
      clnw_pkg::SRC_FSET:   byte_val = cfg_i.function_set;
      clnw_pkg::SRC_DCTL:   byte_val = cfg_i.display_control;
      clnw_pkg::SRC_ENTRY:  byte_val = cfg_i.entry_mode;
      clnw_pkg::SRC_CURSOR: byte_val = cursor_q;
      clnw_pkg::SRC_CHAR:   byte_val = char_q;
      default:              byte_val = uw.lit;
    endcase
  end

  // next step and end of program, resolved on the last nibble of a step
  always_comb begin
    pc_d = pc_q;
    fin  = 1'b0;
    unique case (uw.nxt)
      clnw_pkg::NX_SEQ:  pc_d = pc_q + clnw_pkg::PcW'(1);
      clnw_pkg::NX_DONE: fin = 1'b1;
      clnw_pkg::NX_LINE: begin
        if (char_ok_q) begin
          pc_d = clnw_pkg::PcChar;
        end else if (pad_need) begin
          pc_d = clnw_pkg::PcPad;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        if (pad_need) begin
          pc_d = clnw_pkg::PcPad;
        end else begin
          fin = 1'b1;
        end
      end
    endcase
    fin = fin && byte_end;
    if (!byte_end) begin
      pc_d = pc_q;
    end
  end

  always_comb begin
    run_d  = run_q;
    half_d = half_q;
    col_d  = col_q;
    if (start_i.clear_col) begin
      col_d = '0;
    end
    if (start_i.go) begin
      run_d  = 1'b1;
      half_d = 1'b0;
    end else if (fire) begin
      half_d = !byte_end;
      if (byte_end) begin
        col_d = col_after;
      end
      if (fin) begin
        run_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_d.reg_select     = uw.rs;
    out_d.nibble         = uw.single ? uw.lit[3:0] : (half_q ? byte_val[3:0] : byte_val[7:4]);
    out_d.wait_before_ms = (uw.single || !half_q) ? uw.wb : 6'd0;
    out_d.wait_after_ms  = byte_end ? uw.wa : 2'd0;
    out_d.last_res       = fin;
    if (fire) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      half_q      <= 1'b0;
      pc_q        <= clnw_pkg::PcInit;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      half_q      <= half_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
      if (start_i.go) begin
        pc_q <= start_i.entry;
      end else if (fire) begin
        pc_q <= pc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i.go) begin
      char_q    <= start_i.char_code;
      cursor_q  <= start_i.cursor;
      last_q    <= start_i.last;
      char_ok_q <= start_i.char_ok;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign busy_o      = run_q;
  assign col_o       = col_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CLNW_ASSERT_IMP(a_go_idle, start_i.go, !run_q, "program started while sequencer busy")
  `CLNW_ASSERT_IMP(a_pad_room, run_q && pc_q == clnw_pkg::PcPad, col_q < LineW,
                   "space padding past line width")
  `CLNW_ASSERT_NXT(a_fin_idle, fire && fin, !run_q, "sequencer ran on after final transfer")
  `CLNW_ASSERT_IMP(a_half_byte, run_q && half_q, !uw.single, "low half of a nibble-only step")

endmodule

// ===== src/char_lcd_nibble_write_controller.sv =====
// top level of the 4-bit character lcd write controller
// depends on clnw_pkg and clnw_seq

// Turns init, clear and line-character requests into 4-bit lcd transfers, one
// result per nibble, high nibble first. A request is taken when the sequencer is
// idle; its transfers then leave one per cycle while the output is not stalled,
// from a microprogram rom stepped by clnw_seq. Items that give no transfer leave
// the sequencer idle. The final result of an item is held in the output register
// while the next item is taken.
module char_lcd_nibble_write_controller #(
  parameter int unsigned LINE_WIDTH         = 16,
  parameter int unsigned SECOND_LINE_OFFSET = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [clnw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [clnw_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  clnw_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output clnw_pkg::out_item_t           out_data_o
);

  localparam int unsigned ColW = $clog2(LINE_WIDTH + 1);

  clnw_pkg::cfg_t   cfg_q;
  clnw_pkg::start_t start;
  logic             open_q, open_d, rej_q, rej_d;
  logic             busy, in_fire, opening, new_rej, eff_rej;
  logic [ColW-1:0]  col, col_start;
  logic [8:0]       col_ext, len_ext;
  logic [6:0]       line_addr;

  assign in_fire    = in_valid_i && !busy;
  assign in_stall_o = busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.function_set    <= clnw_pkg::FunctionSetRst;
      cfg_q.display_control <= clnw_pkg::DisplayControlRst;
      cfg_q.entry_mode      <= clnw_pkg::EntryModeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        clnw_pkg::CFG_FUNCTION_SET:    cfg_q.function_set    <= cfg_wdata_i;
        clnw_pkg::CFG_DISPLAY_CONTROL: cfg_q.display_control <= cfg_wdata_i;
        clnw_pkg::CFG_ENTRY_MODE:      cfg_q.entry_mode      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign opening   = (in_data_i.mode == clnw_pkg::MODE_LINE) && !open_q;
  assign new_rej   = (in_data_i.line_number > 2'd1) ||
                     ({1'b0, in_data_i.line_length} > 9'(LINE_WIDTH));
  assign eff_rej   = opening ? new_rej : rej_q;
  assign col_start = opening ? '0 : col;
  assign col_ext   = 9'(col_start);
  assign len_ext   = {1'b0, in_data_i.line_length};
  assign line_addr = (in_data_i.line_number == 2'd1) ? 7'(SECOND_LINE_OFFSET) : 7'd0;

  always_comb begin
    start.go        = 1'b0;
    start.clear_col = in_fire && opening;
    start.entry     = clnw_pkg::PcInit;
    start.char_code = in_data_i.char_code;
    start.cursor    = clnw_pkg::CursorCmd | {1'b0, line_addr};
    start.last      = in_data_i.last;
    start.char_ok   = (col_ext < len_ext) && (col_ext < 9'(LINE_WIDTH));
    open_d          = open_q;
    rej_d           = rej_q;
    if (in_fire) begin
      unique case (in_data_i.mode)
        clnw_pkg::MODE_INIT: begin
          start.go = 1'b1;
          open_d   = 1'b0;
          rej_d    = 1'b0;
        end
        clnw_pkg::MODE_CLEAR: begin
          start.go    = 1'b1;
          start.entry = clnw_pkg::PcClear;
          open_d      = 1'b0;
          rej_d       = 1'b0;
        end
        clnw_pkg::MODE_LINE: begin
          open_d = !in_data_i.last;
          rej_d  = in_data_i.last ? 1'b0 : eff_rej;
          priority if (eff_rej) begin
            start.go = 1'b0;
          end else if (opening) begin
            start.go    = 1'b1;
            start.entry = clnw_pkg::PcCursor;
          end else if (start.char_ok) begin
            start.go    = 1'b1;
            start.entry = clnw_pkg::PcChar;
          end else if (in_data_i.last && (col_ext < 9'(LINE_WIDTH))) begin
            start.go    = 1'b1;
            start.entry = clnw_pkg::PcPad;
          end else begin
            start.go = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rej_q  <= 1'b0;
    end else begin
      open_q <= open_d;
      rej_q  <= rej_d;
    end
  end

  clnw_seq #(
    .LINE_WIDTH (LINE_WIDTH),
    .ColW       (ColW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cfg_i       (cfg_q),
    .busy_o      (busy),
    .col_o       (col),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the 4-bit character lcd write controller
// depends on clnw_pkg and char_lcd_nibble_write_controller; predicts every lcd transfer
// and checks it against the output channel under random idling on both sides
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LINE_W       = 16;
  localparam int unsigned LINE2_OFFSET = 64;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned IDLE_LIMIT   = 2000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [clnw_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [clnw_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  clnw_pkg::in_item_t            in_data_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  clnw_pkg::out_item_t           out_data_o;

  char_lcd_nibble_write_controller #(
    .LINE_WIDTH        (LINE_W),
    .SECOND_LINE_OFFSET(LINE2_OFFSET)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predictor state
  logic [7:0]  fset_reg;
  logic [7:0]  dctl_reg;
  logic [7:0]  entry_reg;
  int unsigned col_count;
  bit          line_open;
  bit          line_rejected;

  clnw_pkg::out_item_t expected_xfers[$];
  clnw_pkg::out_item_t staged_xfer;
  bit                  staged_ok;
  clnw_pkg::out_item_t want_xfer;

  bit          calm_run;
  int unsigned requests_sent;
  int unsigned xfers_checked;
  int unsigned reg_writes;
  int unsigned fail_count;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic string xfer_str(clnw_pkg::out_item_t t);
    return $sformatf("rs=%0b nib=%h wb=%0d wa=%0d last=%0b", t.reg_select, t.nibble,
                     t.wait_before_ms, t.wait_after_ms, t.last_res);
  endfunction

  function automatic clnw_pkg::in_item_t make_request(clnw_pkg::mode_e m, logic [1:0] ln,
                                                      logic [7:0] len, logic [7:0] ch,
                                                      logic lst);
    clnw_pkg::in_item_t it;
    it.mode        = m;
    it.line_number = ln;
    it.line_length = len;
    it.char_code   = ch;
    it.last        = lst;
    return it;
  endfunction

  // one transfer is held back so the final one of a request can get last_res
  task automatic queue_nibble(logic rs, logic [3:0] nib, logic [5:0] wb, logic [1:0] wa);
    if (staged_ok) expected_xfers.push_back(staged_xfer);
    staged_xfer.reg_select     = rs;
    staged_xfer.nibble         = nib;
    staged_xfer.wait_before_ms = wb;
    staged_xfer.wait_after_ms  = wa;
    staged_xfer.last_res       = 1'b0;
    staged_ok = 1'b1;
  endtask

  task automatic queue_byte(logic rs, logic [7:0] b, logic [1:0] wa);
    queue_nibble(rs, b[7:4], 6'd0, 2'd0);
    queue_nibble(rs, b[3:0], 6'd0, wa);
  endtask

  task automatic predict_transfers(clnw_pkg::in_item_t it);
    logic [7:0] cursor;
    case (it.mode)
      clnw_pkg::MODE_INIT: begin
        line_open     = 1'b0;
        line_rejected = 1'b0;
        queue_nibble(1'b0, clnw_pkg::WakeNib[3:0], 6'd50, 2'd0);
        queue_nibble(1'b0, clnw_pkg::WakeNib[3:0], 6'd5, 2'd0);
        queue_nibble(1'b0, clnw_pkg::WakeNib[3:0], 6'd1, 2'd0);
        queue_nibble(1'b0, clnw_pkg::FourBitNib[3:0], 6'd0, 2'd0);
        queue_byte(1'b0, fset_reg, 2'd0);
        queue_byte(1'b0, dctl_reg, 2'd0);
        queue_byte(1'b0, clnw_pkg::ClearCmd, 2'd2);
        queue_byte(1'b0, entry_reg, 2'd0);
      end
      clnw_pkg::MODE_CLEAR: begin
        line_open     = 1'b0;
        line_rejected = 1'b0;
        queue_byte(1'b0, clnw_pkg::ClearCmd, 2'd2);
      end
      clnw_pkg::MODE_LINE: begin
        // line number and rejection come from the opening request only
        if (!line_open) begin
          line_open     = 1'b1;
          col_count     = 0;
          line_rejected = (it.line_number > 2'd1) || (it.line_length > LINE_W);
          if (!line_rejected) begin
            cursor = clnw_pkg::CursorCmd |
                     ((it.line_number == 2'd1) ? 8'(LINE2_OFFSET) & 8'h7F : 8'h00);
            queue_byte(1'b0, cursor, 2'd0);
          end
        end
        if (!line_rejected) begin
          if (col_count < it.line_length && col_count < LINE_W) begin
            queue_byte(1'b1, it.char_code, 2'd0);
            col_count++;
          end
          if (it.last) begin
            while (col_count < LINE_W) begin
              queue_byte(1'b1, clnw_pkg::SpaceChar, 2'd0);
              col_count++;
            end
          end
        end
        if (it.last) begin
          line_open     = 1'b0;
          line_rejected = 1'b0;
        end
      end
      default: ;
    endcase
    if (staged_ok) begin
      staged_xfer.last_res = 1'b1;
      expected_xfers.push_back(staged_xfer);
      staged_ok = 1'b0;
    end
  endtask

  // drive one request and hold it until the block takes it
  task automatic send_request(clnw_pkg::in_item_t it);
    if (!calm_run && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_transfers(it);
    requests_sent++;
  endtask

  task automatic wait_transfers_drained();
    in_valid_i <= 1'b0;
    while (expected_xfers.size() != 0) @(posedge clk_i);
    // requests without transfers may still be in flight
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(clnw_pkg::cfg_idx_e idx, logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      clnw_pkg::CFG_FUNCTION_SET:    fset_reg  = val;
      clnw_pkg::CFG_DISPLAY_CONTROL: dctl_reg  = val;
      clnw_pkg::CFG_ENTRY_MODE:      entry_reg = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic program_regs(logic [7:0] fset, logic [7:0] dctl, logic [7:0] entry);
    wait_transfers_drained();
    write_reg(clnw_pkg::CFG_FUNCTION_SET, fset);
    write_reg(clnw_pkg::CFG_DISPLAY_CONTROL, dctl);
    write_reg(clnw_pkg::CFG_ENTRY_MODE, entry);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_power_up_and_clear();
    send_request(make_request(clnw_pkg::MODE_INIT, 2'd0, 8'd0, 8'h00, 1'b0));
    send_request(make_request(clnw_pkg::MODE_CLEAR, 2'd3, 8'hFF, 8'hFF, 1'b1));
    send_request(make_request(clnw_pkg::MODE_NONE, 2'd1, 8'd5, 8'h41, 1'b1));
  endtask

  task automatic test_line_requests();
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd0, 8'd3, 8'h00, 1'b0));
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd0, 8'd3, 8'hFF, 1'b0));
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd0, 8'd3, 8'h41, 1'b1));
    // empty line on the second row is all padding
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd1, 8'd0, 8'hFF, 1'b1));
    // rejected lines
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd2, 8'd1, 8'h42, 1'b1));
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd3, 8'd16, 8'h43, 1'b1));
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd0, 8'd17, 8'h44, 1'b1));
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd1, 8'd255, 8'h45, 1'b0));
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd0, 8'd3, 8'h46, 1'b1));
    // more characters than the line length, the extra one is dropped
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd1, 8'd2, 8'h78, 1'b0));
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd0, 8'd2, 8'h79, 1'b0));
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd1, 8'd2, 8'h7A, 1'b1));
  endtask

  task automatic test_abandoned_lines();
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd0, 8'd5, 8'h41, 1'b0));
    send_request(make_request(clnw_pkg::MODE_INIT, 2'd2, 8'd200, 8'h00, 1'b1));
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd1, 8'd4, 8'h42, 1'b0));
    send_request(make_request(clnw_pkg::MODE_CLEAR, 2'd0, 8'd0, 8'h00, 1'b0));
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd0, 8'd4, 8'h43, 1'b0));
    send_request(make_request(clnw_pkg::MODE_NONE, 2'd3, 8'd9, 8'h44, 1'b1));
    // shorter length on the closing item suppresses its character
    send_request(make_request(clnw_pkg::MODE_LINE, 2'd1, 8'd1, 8'h45, 1'b1));
  endtask

  task automatic test_register_settings();
    program_regs(8'h00, 8'h00, 8'h00);
    @(posedge clk_i);
    write_reg(clnw_pkg::CFG_UNUSED, 8'hA5);
    cfg_we_i <= 1'b0;
    send_request(make_request(clnw_pkg::MODE_INIT, 2'd0, 8'd0, 8'h00, 1'b0));
    program_regs(8'hFF, 8'hFF, 8'hFF);
    send_request(make_request(clnw_pkg::MODE_INIT, 2'd1, 8'd1, 8'h01, 1'b1));
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned ln;
    int unsigned len;
    int unsigned k;
    int unsigned i;
    logic [7:0]  len_now;
    start = requests_sent;
    while (requests_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed line with random content
        ln  = $urandom_range(0, 1);
        len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, LINE_W);
        case ($urandom_range(0, 3))
          0:       k = 1;
          1:       k = $urandom_range(1, len + 3);
          default: k = (len == 0) ? 1 : len;
        endcase
        for (i = 0; i < k; i++) begin
          len_now = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'(len);
          send_request(make_request(clnw_pkg::MODE_LINE,
                                    (i == 0) ? 2'(ln) : 2'($urandom_range(0, 3)),
                                    len_now, 8'($urandom), i == k - 1));
        end
      end else if (pick < 78) begin
        // rejected line
        k = $urandom_range(1, 3);
        if ($urandom_range(0, 1) == 0)
          send_request(make_request(clnw_pkg::MODE_LINE, 2'($urandom_range(2, 3)),
                                    8'($urandom_range(0, LINE_W)), 8'($urandom), k == 1));
        else
          send_request(make_request(clnw_pkg::MODE_LINE, 2'($urandom_range(0, 1)),
                                    8'($urandom_range(LINE_W + 1, 255)), 8'($urandom),
                                    k == 1));
        for (i = 1; i < k; i++)
          send_request(make_request(clnw_pkg::MODE_LINE, 2'($urandom), 8'($urandom),
                                    8'($urandom), i == k - 1));
      end else if (pick < 84) begin
        // line cut short by init or clear
        k = $urandom_range(1, 3);
        len = $urandom_range(0, LINE_W);
        for (i = 0; i < k; i++)
          send_request(make_request(clnw_pkg::MODE_LINE, 2'($urandom_range(0, 1)), 8'(len),
                                    8'($urandom), 1'b0));
        send_request(make_request(($urandom_range(0, 2) == 0) ? clnw_pkg::MODE_INIT
                                                               : clnw_pkg::MODE_CLEAR,
                                  2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom)));
      end else if (pick < 88) begin
        send_request(make_request(clnw_pkg::MODE_INIT, 2'($urandom), 8'($urandom),
                                  8'($urandom), 1'($urandom)));
      end else if (pick < 94) begin
        send_request(make_request(clnw_pkg::MODE_CLEAR, 2'($urandom), 8'($urandom),
                                  8'($urandom), 1'($urandom)));
      end else begin
        // noise
        send_request(make_request(clnw_pkg::mode_e'($urandom_range(0, 3)), 2'($urandom),
                                  8'($urandom), 8'($urandom), 1'($urandom)));
      end
    end
  endtask

  // receiver stalls in bursts, with longer free-running stretches in between
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm_run) begin
        if ($urandom_range(0, 3) == 0) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          repeat ($urandom_range(20, 80)) @(posedge clk_i);
        end
      end
    end
  end

  // transfer checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      xfers_checked++;
      if (expected_xfers.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected transfer: %s", xfer_str(out_data_o));
      end else begin
        want_xfer = expected_xfers.pop_front();
        if (out_data_o.reg_select !== want_xfer.reg_select ||
            out_data_o.nibble !== want_xfer.nibble ||
            out_data_o.wait_before_ms !== want_xfer.wait_before_ms ||
            out_data_o.wait_after_ms !== want_xfer.wait_after_ms ||
            out_data_o.last_res !== want_xfer.last_res) begin
          fail_count++;
          if (fail_count <= 10)
            $display("transfer mismatch: expected %s, got %s", xfer_str(want_xfer),
                     xfer_str(out_data_o));
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = clnw_pkg::CFG_FUNCTION_SET;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    fset_reg      = clnw_pkg::FunctionSetRst;
    dctl_reg      = clnw_pkg::DisplayControlRst;
    entry_reg     = clnw_pkg::EntryModeRst;
    col_count     = 0;
    line_open     = 1'b0;
    line_rejected = 1'b0;
    staged_ok     = 1'b0;
    calm_run      = 1'b0;
    requests_sent = 0;
    xfers_checked = 0;
    reg_writes    = 0;
    fail_count    = 0;
    idle_cycles   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_up_and_clear();
    test_line_requests();
    test_abandoned_lines();
    test_register_settings();
    program_regs(clnw_pkg::FunctionSetRst, clnw_pkg::DisplayControlRst,
                 clnw_pkg::EntryModeRst);
    test_random_traffic(100);
    program_regs(8'($urandom), 8'($urandom), 8'($urandom));
    test_random_traffic(90);
    program_regs(8'($urandom), 8'($urandom), 8'($urandom));
    calm_run = 1'b1;
    test_random_traffic(60);

    wait_transfers_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d requests (init, clear, line and idle) and %0d register writes",
             requests_sent, reg_writes);
    $display("checked %0d lcd transfers, %0d failures", xfers_checked, fail_count);
    if (fail_count == 0 && expected_xfers.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
